// ===== rtl/centered_1d_convolution_top_macros.svh =====
`ifndef CENTERED_1D_CONVOLUTION_TOP_MACROS_SVH
`define CENTERED_1D_CONVOLUTION_TOP_MACROS_SVH

// same-cycle implication
`define C1DC_ASSERT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define C1DC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/c1dc_pkg.sv =====
package c1dc_pkg;

	localparam int MAX_TAPS_DEF    = 7;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int NUM_COEFS       = 7;
	localparam int COEF_BITS       = 16;
	localparam int LEN_BITS        = 3;
	localparam int AHEAD_BITS      = 2;
	localparam int VALUE_BITS      = 34;
	localparam int OUT_TDATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
	localparam int CFG_IDX_BITS    = 3;
	localparam int CFG_DATA_BITS   = 16;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_COEF_0      = 3'd0,
		REG_COEF_1      = 3'd1,
		REG_COEF_2      = 3'd2,
		REG_COEF_3      = 3'd3,
		REG_COEF_4      = 3'd4,
		REG_COEF_5      = 3'd5,
		REG_COEF_6      = 3'd6,
		REG_MASK_LENGTH = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic valid;
		logic clear;
	} push_t;

	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

	function automatic logic [LEN_BITS-1:0] taps_in_use(input logic [LEN_BITS-1:0] mask,
		input int max_taps);
		logic [LEN_BITS-1:0] len;
		len = (mask == '0) ? LEN_BITS'(1) : mask;
		if (int'(len) > max_taps)
			len = LEN_BITS'(max_taps);
		return len;
	endfunction

	function automatic logic [AHEAD_BITS-1:0] ahead_of(input logic [LEN_BITS-1:0] len);
		logic [LEN_BITS-1:0] a;
		a = len - LEN_BITS'(1) - (len >> 1);
		return a[AHEAD_BITS-1:0];
	endfunction

endpackage

// ===== rtl/c1dc_cell.sv =====
module c1dc_cell #(
	parameter int SAMPLE_BITS = c1dc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     push,
	input  logic                                     clr,
	input  logic signed [SAMPLE_BITS-1:0]            din,
	input  logic signed [c1dc_pkg::COEF_BITS-1:0]    coef,
	input  logic                                     take,
	output logic signed [SAMPLE_BITS-1:0]            dout,
	output logic signed [c1dc_pkg::VALUE_BITS-1:0]   prod
);
	import c1dc_pkg::*;

	logic signed [SAMPLE_BITS-1:0]           d_q;
	logic signed [SAMPLE_BITS+COEF_BITS-1:0] full;
	logic signed [VALUE_BITS-1:0]            prod_q;

	assign full = d_q * coef;

	always_ff @(posedge clk) begin
		if (push)
			d_q <= clr ? '0 : din;
		if (take)
			prod_q <= VALUE_BITS'(full);
	end

	assign dout = d_q;
	assign prod = prod_q;

endmodule

// ===== rtl/c1dc_tree.sv =====
module c1dc_tree #(
	parameter int LEAVES = c1dc_pkg::MAX_TAPS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic signed [c1dc_pkg::VALUE_BITS-1:0]   leaf [LEAVES],
	input  c1dc_pkg::tag_t                           tag_in,
	input  logic                                     out_ready,
	output logic                                     take,
	output logic signed [c1dc_pkg::VALUE_BITS-1:0]   root,
	output c1dc_pkg::tag_t                           tag_out
);
	import c1dc_pkg::*;

	localparam int LEVELS = (LEAVES < 2) ? 1 : $clog2(LEAVES);
	localparam int N      = 1 << LEVELS;

	logic signed [VALUE_BITS-1:0] leaf_w [N];
	logic signed [VALUE_BITS-1:0] node_q [1:N-1];
	tag_t                         tag_q  [0:LEVELS];
	logic                         en     [0:LEVELS];

	for (genvar i = 0; i < N; i++) begin : g_leaf
		if (i < LEAVES) begin : g_used
			assign leaf_w[i] = leaf[i];
		end else begin : g_pad
			assign leaf_w[i] = '0;
		end
	end

	always_comb begin
		en[LEVELS] = !tag_q[LEVELS].valid || out_ready;
		for (int l = LEVELS - 1; l >= 0; l--)
			en[l] = !tag_q[l].valid || en[l+1];
	end

	for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
		for (genvar i = (1 << (LEVELS - l)); i < (1 << (LEVELS - l + 1)); i++) begin : g_node
			if (l == 1) begin : g_bottom
				always_ff @(posedge clk) begin
					if (en[l])
						node_q[i] <= leaf_w[2*i-N] + leaf_w[2*i+1-N];
				end
			end else begin : g_upper
				always_ff @(posedge clk) begin
					if (en[l])
						node_q[i] <= node_q[2*i] + node_q[2*i+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l <= LEVELS; l++)
				tag_q[l] <= '0;
		end else begin
			if (en[0])
				tag_q[0] <= tag_in;
			for (int l = 1; l <= LEVELS; l++)
				if (en[l])
					tag_q[l] <= tag_q[l-1];
		end
	end

	assign take    = en[0];
	assign root    = node_q[1];
	assign tag_out = tag_q[LEVELS];

endmodule

// ===== rtl/c1dc_seq.sv =====
`include "centered_1d_convolution_top_macros.svh"

module c1dc_seq #(
	parameter int SAMPLE_BITS = c1dc_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_TAPS    = c1dc_pkg::MAX_TAPS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [c1dc_pkg::LEN_BITS-1:0]        len,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	input  logic                                 last,
	input  logic                                 take,
	output c1dc_pkg::push_t                      push,
	output logic signed [SAMPLE_BITS-1:0]        push_sample,
	output c1dc_pkg::tag_t                       tag
);
	import c1dc_pkg::*;

	localparam int SEEN_W = $clog2(MAX_TAPS + 1);

	logic [SEEN_W-1:0]     seen_q;
	logic [SEEN_W-1:0]     seen_base;
	logic [SEEN_W-1:0]     seen_new;
	logic                  block_start_q;
	logic                  flush_q;
	logic [AHEAD_BITS-1:0] remain_q;
	logic [AHEAD_BITS-1:0] ahead;
	tag_t                  tag_q;
	logic                  push_ok;
	logic                  acc;
	logic                  emit;
	logic                  last_push;

	assign ahead = ahead_of(len);

	always_comb begin
		push_ok     = !tag_q.valid || take;
		s_tready    = push_ok && !flush_q;
		acc         = s_tvalid && s_tready;
		push.valid  = acc || (flush_q && push_ok);
		push.clear  = acc && block_start_q;
		push_sample = acc ? sample : '0;
		seen_base   = push.clear ? '0 : seen_q;
		seen_new    = (seen_base == SEEN_W'(MAX_TAPS)) ? seen_base : seen_base + SEEN_W'(1);
		emit        = push.valid && (int'(seen_new) > int'(ahead));
		last_push   = acc ? (last && (ahead == '0)) : (remain_q == AHEAD_BITS'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q        <= '0;
			block_start_q <= 1'b1;
			flush_q       <= 1'b0;
			remain_q      <= '0;
			tag_q         <= '0;
		end else begin
			if (push.valid)
				seen_q <= seen_new;
			if (acc) begin
				block_start_q <= last;
				if (last && (ahead != '0)) begin
					flush_q  <= 1'b1;
					remain_q <= ahead;
				end
			end else if (flush_q && push_ok) begin
				remain_q <= remain_q - AHEAD_BITS'(1);
				if (remain_q == AHEAD_BITS'(1))
					flush_q <= 1'b0;
			end
			if (push.valid) begin
				tag_q.valid <= emit;
				tag_q.last  <= last_push;
			end else if (take) begin
				tag_q.valid <= 1'b0;
			end
		end
	end

	assign tag = tag_q;

	`C1DC_ASSERT_NEXT(a_flush_after_last, clk, arst_n, acc && last && (ahead != '0), flush_q && (remain_q == ahead), "last word did not start the flush")
	`C1DC_ASSERT(a_flush_count, clk, arst_n, flush_q, remain_q != '0, "flush running with no pushes left")
	`C1DC_ASSERT_NEXT(a_block_restart, clk, arst_n, push.valid && push.clear, seen_q == SEEN_W'(1), "block start did not restart the count")
	`C1DC_ASSERT(a_seen_bound, clk, arst_n, 1'b1, seen_q <= SEEN_W'(MAX_TAPS), "seen count beyond tap count")
	`C1DC_ASSERT(a_hold_window, clk, arst_n, tag_q.valid && !take, !push.valid, "delay line moved before its products were taken")

endmodule

// ===== rtl/centered_1d_convolution_top.sv =====
// channel | dir | tdata (low bit up)            | tlast             | tuser
// s_      | in  | sample, zero fill to bytes    | last sample       | -
// m_      | out | value, zero fill to bytes     | last result       | -
// cfg_    | in  | cfg_index selects coef_0..6 or mask_length, no read-back
// One sample is taken per cycle while s_tready is high; a result passes the product stage
// and every add-tree level after the sample that completes its window.
// A last sample with look-ahead A = L-1-floor(L/2) holds s_tready low while A zeros
// are shifted through the tap chain.
// Reset clears the handshake state and sets mask_length to one, coefficients to zero.
// m_tready low fills the product and tree stages before s_tready drops.
module centered_1d_convolution_top #(
	parameter int MAX_TAPS    = c1dc_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = c1dc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,   // sample
	input  logic                                   s_tlast,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [c1dc_pkg::OUT_TDATA_BITS-1:0]    m_tdata,   // value
	output logic                                   m_tlast,
	input  logic                                   cfg_we,
	input  logic [c1dc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [c1dc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
	import c1dc_pkg::*;

	logic signed [COEF_BITS-1:0]   coef_q [NUM_COEFS];
	logic [LEN_BITS-1:0]           mask_q;
	logic [LEN_BITS-1:0]           len;
	logic signed [COEF_BITS-1:0]   ce     [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] tap    [MAX_TAPS];
	logic signed [VALUE_BITS-1:0]  prod   [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] push_sample;
	logic signed [VALUE_BITS-1:0]  root;
	push_t                         push;
	tag_t                          tag_s0;
	tag_t                          tag_out;
	logic                          take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++)
				coef_q[i] <= '0;
			mask_q <= LEN_BITS'(1);
		end else if (cfg_we) begin
			if (cfg_index == REG_MASK_LENGTH)
				mask_q <= cfg_data[LEN_BITS-1:0];
			else
				coef_q[cfg_index] <= cfg_data;
		end
	end

	assign len = taps_in_use(mask_q, MAX_TAPS);

	c1dc_seq #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_TAPS   (MAX_TAPS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.len        (len),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.sample     (s_tdata[SAMPLE_BITS-1:0]),
		.last       (s_tlast),
		.take       (take),
		.push       (push),
		.push_sample(push_sample),
		.tag        (tag_s0)
	);

	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
		if (k < NUM_COEFS) begin : g_coef
			assign ce[k] = (k < int'(len)) ? coef_q[LEN_BITS'(int'(len) - 1 - k)] : '0;
		end else begin : g_nocoef
			assign ce[k] = '0;
		end

		if (k == 0) begin : g_head
			c1dc_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
				.clk (clk),
				.push(push.valid),
				.clr (1'b0),
				.din (push_sample),
				.coef(ce[k]),
				.take(take),
				.dout(tap[k]),
				.prod(prod[k])
			);
		end else begin : g_body
			c1dc_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
				.clk (clk),
				.push(push.valid),
				.clr (push.clear),
				.din (tap[k-1]),
				.coef(ce[k]),
				.take(take),
				.dout(tap[k]),
				.prod(prod[k])
			);
		end
	end

	c1dc_tree #(.LEAVES(MAX_TAPS)) u_tree (
		.clk      (clk),
		.arst_n   (arst_n),
		.leaf     (prod),
		.tag_in   (tag_s0),
		.out_ready(m_tready),
		.take     (take),
		.root     (root),
		.tag_out  (tag_out)
	);

	assign m_tvalid = tag_out.valid;
	assign m_tlast  = tag_out.last;
	assign m_tdata  = {{(OUT_TDATA_BITS - VALUE_BITS){1'b0}}, root};

endmodule
